// ===== src/mx_pkg.sv =====
// mx_pkg: shared types and constants for the modular exponentiation block
// holds register index codes and the controller/datapath command and status structs
// no dependencies

package mx_pkg;

    // configuration register index
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_MODULUS  = 2'd0;
    localparam t_reg_idx REG_EXPONENT = 2'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take a new message, init accumulator and exponent
        logic red_step;   // one bit of the initial base reduction
        logic mul_start;  // clear partial products, load multiplier bits from base
        logic mul_step;   // one bit of the paired multiply and square
        logic out_load;   // copy the final value into the result register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic cnt_last;   // last bit of the current serial pass
        logic e_zero;     // no exponent bits left
    } t_status;

endpackage

// ===== src/modular_exponentiation.sv =====
// modular_exponentiation: message ^ exponent mod modulus, right-to-left square-and-multiply
// the multiply and the squaring of each exponent bit run side by side, one bit per cycle each
// one request at a time, accepted only while idle; a finished result waits in its own output register
// reset: synchronous active low, modulus and exponent return to 1, no request pending

module modular_exponentiation #(
    parameter int WORD_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  mx_pkg::t_reg_idx      i_cfg_idx,
    input  logic [WORD_BITS-1:0]  i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [WORD_BITS-1:0]  i_message_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [WORD_BITS-1:0]  o_result_out
);

    mx_pkg::t_cmd    w_cmd;
    mx_pkg::t_status w_status;

    // sequencer
    mx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic and key storage
    mx_datapath #(.WORD_BITS(WORD_BITS)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_message_in (i_message_in),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_result_out (o_result_out)
    );

endmodule

// ===== src/mx_mulstep.sv =====
// mx_mulstep: one bit step of the serial modular multiply, (2r + bit*a) mod n
// operands r and a must be below n; depends on nothing else

module mx_mulstep #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0] i_r,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic                 i_bit,
    input  logic [WORD_BITS-1:0] i_n,
    output logic [WORD_BITS-1:0] o_r
);

    localparam int TW = WORD_BITS + 2;

    logic [TW-1:0] w_t;
    logic [TW-1:0] w_n1;
    logic [TW-1:0] w_n2;

    // doubled partial plus optional addend, below 3n
    assign w_t  = {1'b0, i_r, 1'b0} + (i_bit ? {2'b00, i_a} : TW'(0));
    assign w_n1 = {2'b00, i_n};
    assign w_n2 = {1'b0, i_n, 1'b0};

    // subtract n or 2n so the result lands below n
    always_comb begin
        if (w_t >= w_n2) begin
            o_r = WORD_BITS'(w_t - w_n2);
        end else if (w_t >= w_n1) begin
            o_r = WORD_BITS'(w_t - w_n1);
        end else begin
            o_r = WORD_BITS'(w_t);
        end
    end

endmodule

// ===== src/mx_datapath.sv =====
// mx_datapath: key registers, accumulator, base and two serial modular multipliers
// depends on mx_pkg and mx_mulstep

module mx_datapath #(
    parameter int WORD_BITS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  mx_pkg::t_reg_idx          i_cfg_idx,
    input  logic [WORD_BITS-1:0]      i_cfg_wdata,
    input  logic [WORD_BITS-1:0]      i_message_in,
    input  mx_pkg::t_cmd              i_cmd,
    output mx_pkg::t_status           o_status,
    output logic [WORD_BITS-1:0]      o_result_out
);

    localparam int CW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] r_mod;
    logic [WORD_BITS-1:0] r_exp;
    logic [WORD_BITS-1:0] r_e;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_base;
    logic [WORD_BITS-1:0] r_pa;
    logic [WORD_BITS-1:0] r_pb;
    logic [WORD_BITS-1:0] r_bsh;
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] r_result;

    logic [WORD_BITS-1:0] w_step_a;
    logic [WORD_BITS-1:0] w_step_b;
    logic [WORD_BITS-1:0] w_addend_b;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WORD_BITS'(1);
            r_exp <= WORD_BITS'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == mx_pkg::REG_MODULUS) begin
                r_mod <= i_cfg_wdata;
            end
            if (i_cfg_idx == mx_pkg::REG_EXPONENT) begin
                r_exp <= i_cfg_wdata;
            end
        end
    end

    // unit b reduces the message with addend 1, later squares the base
    assign w_addend_b = i_cmd.red_step ? WORD_BITS'(1) : r_base;

    // accumulator times base
    mx_mulstep #(.WORD_BITS(WORD_BITS)) u_mul_a (
        .i_r   (r_pa),
        .i_a   (r_acc),
        .i_bit (r_bsh[WORD_BITS-1]),
        .i_n   (r_mod),
        .o_r   (w_step_a)
    );

    // base times base, or message mod n
    mx_mulstep #(.WORD_BITS(WORD_BITS)) u_mul_b (
        .i_r   (r_pb),
        .i_a   (w_addend_b),
        .i_bit (r_bsh[WORD_BITS-1]),
        .i_n   (r_mod),
        .o_r   (w_step_b)
    );

    // status to the controller
    assign o_status.cnt_last = (r_cnt == CW'(WORD_BITS - 1));
    assign o_status.e_zero   = (r_e == '0);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bsh <= i_message_in;
            r_pb  <= '0;
            r_cnt <= '0;
            r_acc <= (r_mod == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            r_e   <= r_exp;
        end
        if (i_cmd.red_step) begin
            r_pb  <= w_step_b;
            r_bsh <= {r_bsh[WORD_BITS-2:0], 1'b0};
            r_cnt <= r_cnt + CW'(1);
            if (o_status.cnt_last) begin
                r_base <= w_step_b;
            end
        end
        if (i_cmd.mul_start) begin
            r_bsh <= r_base;
            r_pa  <= '0;
            r_pb  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.mul_step) begin
            r_pa  <= w_step_a;
            r_pb  <= w_step_b;
            r_bsh <= {r_bsh[WORD_BITS-2:0], 1'b0};
            r_cnt <= r_cnt + CW'(1);
            if (o_status.cnt_last) begin
                if (r_e[0]) begin
                    r_acc <= w_step_a;
                end
                r_base <= w_step_b;
                r_e    <= {1'b0, r_e[WORD_BITS-1:1]};
            end
        end
        if (i_cmd.out_load) begin
            r_result <= (r_mod == '0) ? '0 : r_acc;
        end
    end

    assign o_result_out = r_result;

endmodule

// ===== src/mx_ctrl.sv =====
// mx_ctrl: sequencer for reduction, multiply/square passes and result handoff
// depends on mx_pkg

module mx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mx_pkg::t_status  i_status,
    output mx_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RED   = 5'b00010,
        S_CHECK = 5'b00100,
        S_MUL   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                o_cmd.red_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.e_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_CHECK;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output request flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/mx_checker.sv =====
// mx_checker: port-level assertions for modular_exponentiation
// bound to the top level below; depends on no package

module mx_checker #(
    parameter int WORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic [WORD_BITS-1:0] o_result_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result request dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result_out))
        else $error("result changed while stalled");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a request is in work");

    // a new result is handed over as the block goes idle
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result appeared while the block is still busy");

    // reset clears the output request
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result request survived reset");

endmodule

bind modular_exponentiation mx_checker #(.WORD_BITS(WORD_BITS)) u_mx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_result_out (o_result_out)
);

// ===== verif/modular_exponentiation_tb.sv =====
`timescale 1ns / 100ps
// modular_exponentiation_tb: self-checking bench for the modular exponentiation block
// sends message requests through key settings and checks each result against a wide-product
// predictor; depends on mx_pkg and modular_exponentiation

module modular_exponentiation_tb;

    localparam int WB           = 64;
    localparam int IDLE_LIMIT   = 20000;   // several times the longest request latency
    localparam int DRAIN_CYCLES = 4300;    // one full-length exponentiation
    localparam int RANDOM_ITEMS = 120;
    localparam mx_pkg::t_reg_idx REG_SPARE_A = 2'd2;
    localparam mx_pkg::t_reg_idx REG_SPARE_B = 2'd3;
    localparam logic [WB-1:0] ALL_ONES = '1;

    typedef struct {
        logic [WB-1:0] msg;
        bit            hold;   // wait for every outstanding result before sending
    } t_msg_req;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_cfg_we     = 1'b0;
    mx_pkg::t_reg_idx i_cfg_idx    = mx_pkg::REG_MODULUS;
    logic [WB-1:0]    i_cfg_wdata  = '0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_ready;
    logic [WB-1:0]    i_message_in = '0;
    logic             o_out_valid;
    logic             i_out_ready  = 1'b0;
    logic [WB-1:0]    o_result_out;

    // key copies seen by the predictor
    logic [WB-1:0] mod_model = WB'(1);
    logic [WB-1:0] exp_model = WB'(1);

    t_msg_req      msg_pending[$];
    logic [WB-1:0] power_q[$];
    int            n_issued  = 0;
    int            n_retired = 0;
    int            errors    = 0;
    bit            quiet     = 1'b0;
    int            gap_left  = 0;
    int            stall_left = 0;
    int            idle_cycles = 0;

    modular_exponentiation #(
        .WORD_BITS(WB)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_message_in (i_message_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result_out (o_result_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // right-to-left square and multiply on exact double-width products
    function automatic logic [WB-1:0] modexp(input logic [WB-1:0] msg,
                                             input logic [WB-1:0] e,
                                             input logic [WB-1:0] n);
        logic [2*WB-1:0] wide;
        logic [WB-1:0]   acc;
        logic [WB-1:0]   base;
        if (n == '0)
            return '0;
        acc  = (n == WB'(1)) ? '0 : WB'(1);
        base = msg % n;
        for (int b = 0; b < WB; b++) begin
            if (e[b]) begin
                wide = {{WB{1'b0}}, acc} * {{WB{1'b0}}, base};
                acc  = WB'(wide % {{WB{1'b0}}, n});
            end
            wide = {{WB{1'b0}}, base} * {{WB{1'b0}}, base};
            base = WB'(wide % {{WB{1'b0}}, n});
        end
        return acc;
    endfunction

    function automatic logic [WB-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // random value whose highest set bit is bit w-1
    function automatic logic [WB-1:0] rand_bits(input int w);
        logic [WB-1:0] v;
        v = rand_word() >> (WB - w);
        v[w-1] = 1'b1;
        return v;
    endfunction

    task automatic write_reg(input mx_pkg::t_reg_idx idx, input logic [WB-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == mx_pkg::REG_MODULUS)
            mod_model = data;
        else if (idx == mx_pkg::REG_EXPONENT)
            exp_model = data;
    endtask

    task automatic push_msg(input logic [WB-1:0] msg, input bit hold);
        t_msg_req r;
        r.msg  = msg;
        r.hold = hold;
        msg_pending.push_back(r);
    endtask

    task automatic wait_idle();
        while (msg_pending.size() != 0 || n_issued != n_retired)
            @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin : driver
        t_msg_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                power_q.push_back(modexp(i_message_in, exp_model, mod_model));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (msg_pending.size() != 0 &&
                             !(msg_pending[0].hold && n_issued != n_retired)) begin
                    req = msg_pending.pop_front();
                    n_issued++;
                    i_in_valid   <= 1'b1;
                    i_message_in <= req.msg;
                    gap_left     <= quiet ? 0 : $urandom_range(0, 5);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin : monitor
        logic [WB-1:0] want;
        int            stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if (power_q.size() == 0) begin
                $error("result_out with no request pending: actual %h", o_result_out);
                errors++;
            end else begin
                want = power_q.pop_front();
                n_retired++;
                if (o_result_out !== want) begin
                    $error("result_out mismatch: expected %h, actual %h", want, o_result_out);
                    errors++;
                end
            end
            stall = quiet ? 0 : $urandom_range(0, 5);
            stall_left  <= stall;
            i_out_ready <= (stall == 0);
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("modular_exponentiation regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [WB-1:0] m;
        logic [WB-1:0] e;
        logic [WB-1:0] msg;
        int            n_random;
        int            pick;
        int            count;
        n_random = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset keys: modulus of one gives zero
        push_msg('0, 1'b0);
        push_msg(ALL_ONES, 1'b0);

        // widest modulus and exponent
        wait_idle();
        quiet = 1'b1;
        write_reg(mx_pkg::REG_MODULUS, ALL_ONES);
        write_reg(mx_pkg::REG_EXPONENT, ALL_ONES);
        push_msg('0, 1'b0);
        push_msg(WB'(1), 1'b0);
        push_msg(WB'(2), 1'b0);
        push_msg(ALL_ONES, 1'b0);
        push_msg(ALL_ONES - WB'(1), 1'b0);

        // zero modulus
        wait_idle();
        quiet = 1'b0;
        write_reg(mx_pkg::REG_MODULUS, '0);
        write_reg(mx_pkg::REG_EXPONENT, rand_bits(12));
        push_msg(WB'(5), 1'b0);
        push_msg(ALL_ONES, 1'b0);

        // zero exponent, then zero exponent with modulus of one
        wait_idle();
        write_reg(mx_pkg::REG_MODULUS, rand_bits(WB));
        write_reg(mx_pkg::REG_EXPONENT, '0);
        push_msg('0, 1'b0);
        push_msg(WB'(7), 1'b1);
        wait_idle();
        write_reg(mx_pkg::REG_MODULUS, WB'(1));
        push_msg(rand_word(), 1'b0);

        // large modulus, common public exponent; spare indexes must not disturb keys
        wait_idle();
        m = rand_bits(WB) | WB'(1);
        write_reg(mx_pkg::REG_MODULUS, m);
        write_reg(mx_pkg::REG_EXPONENT, WB'(65537));
        write_reg(REG_SPARE_A, ALL_ONES);
        write_reg(REG_SPARE_B, '0);
        push_msg(m - WB'(1), 1'b0);
        push_msg(m, 1'b0);
        push_msg(m + WB'(1), 1'b0);
        push_msg(rand_word(), 1'b0);
        push_msg(rand_word(), 1'b1);
        push_msg(rand_word(), 1'b0);

        // tiny modulus, exponent with only the top bit set
        wait_idle();
        write_reg(mx_pkg::REG_MODULUS, WB'(2));
        write_reg(mx_pkg::REG_EXPONENT, {1'b1, {(WB-1){1'b0}}});
        push_msg(WB'(3), 1'b0);
        push_msg(WB'(4), 1'b0);

        // random key phases
        while (n_random < RANDOM_ITEMS) begin
            wait_idle();
            quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 11);
            case (pick)
                0:       m = '0;
                1:       m = WB'(1);
                2:       m = ALL_ONES;
                default: m = rand_bits($urandom_range(1, WB));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       e = '0;
                1, 2:    e = rand_bits(WB);
                3:       e = rand_word();
                default: e = rand_bits($urandom_range(1, 20));
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_reg(mx_pkg::REG_MODULUS, m);
                write_reg(mx_pkg::REG_EXPONENT, e);
            end else begin
                write_reg(mx_pkg::REG_EXPONENT, e);
                write_reg(mx_pkg::REG_MODULUS, m);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rand_word());
            count = $urandom_range(8, 16);
            repeat (count) begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       msg = '0;
                    1:       msg = m - WB'(1);
                    2:       msg = (m != '0) ? rand_word() % m : rand_word();
                    3:       msg = WB'($urandom_range(0, 255));
                    default: msg = rand_word();
                endcase
                push_msg(msg, $urandom_range(0, 15) == 0);
                n_random++;
            end
        end

        // let everything drain, then watch for stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (power_q.size() != 0) begin
            $error("%0d expected results never arrived", power_q.size());
            errors++;
        end
        if (errors == 0)
            $display("modular_exponentiation regression: pass");
        else
            $display("modular_exponentiation regression: fail");
        $finish;
    end

endmodule
